FILE: rtl/ryuv_pkg.sv
// Shared constants, codes and payload types of the RGB to YUV chroma subsampler.
package ryuv_pkg;

   localparam int MAX_WIDTH   = 4096;
   localparam int MAX_HEIGHT  = 4096;

   localparam int DIM_W       = 13;
   localparam int CSR_INDEX_W = 2;
   localparam int OFS_W       = 25;
   localparam int LUMA_OFS_W  = 24;
   localparam int CIDX_W      = 23;
   localparam int COL_W       = $clog2(MAX_WIDTH);
   localparam int ROW_W       = $clog2(MAX_HEIGHT);
   localparam int LINE_DEPTH  = MAX_WIDTH / 2;
   localparam int LINE_AW     = $clog2(LINE_DEPTH);
   localparam int QUEUE_DEPTH = 4;

   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_OUT_FORMAT   = 2'd2;

   localparam logic [1:0] FMT_NV12    = 2'd0;
   localparam logic [1:0] FMT_YV16    = 2'd1;
   localparam logic [1:0] FMT_YUV422P = 2'd2;

   localparam logic [1:0] PLANE_LUMA = 2'd0;
   localparam logic [1:0] PLANE_U    = 2'd1;
   localparam logic [1:0] PLANE_V    = 2'd2;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } pixel_type;

   typedef struct packed {
      logic [OFS_W-1:0] byte_offset;
      logic [7:0]       sample_value;
      logic [1:0]       plane;
      logic             last_of_item;
   } result_type;

   // All results caused by one pixel: luma always, chroma pair optionally.
   typedef struct packed {
      logic [LUMA_OFS_W-1:0] luma_offset;
      logic [7:0]            luma_value;
      logic                  has_chroma;
      logic [OFS_W-1:0]      u_offset;
      logic [7:0]            u_value;
      logic [OFS_W-1:0]      v_offset;
      logic [7:0]            v_value;
   } group_type;

   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
      logic [1:0]       out_format;
      logic [OFS_W-1:0] luma_size;
      logic [OFS_W-1:0] second_base;
   } frame_cfg_type;

endpackage

FILE: rtl/ryuv_front.sv
// Front end: pixel intake, raster tracking, color conversion and chroma averaging.
module ryuv_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  ryuv_pkg::pixel_type     req_pixel,
   input  ryuv_pkg::frame_cfg_type cfg,
   input  logic                    restart,
   output logic                    grp_push,
   output ryuv_pkg::group_type     grp,
   input  logic                    grp_full
);
   import ryuv_pkg::*;

   localparam int ACC_W  = 26;
   localparam int PROD_W = 24;
   localparam int PAIR_W = 9;

   localparam logic [15:0] COEF_Y_R = 16'd19595;
   localparam logic [15:0] COEF_Y_G = 16'd38470;
   localparam logic [15:0] COEF_Y_B = 16'd7471;
   localparam logic [15:0] COEF_U_R = 16'd11076;
   localparam logic [15:0] COEF_U_G = 16'd21758;
   localparam logic [15:0] COEF_V_G = 16'd27460;
   localparam logic [15:0] COEF_V_B = 16'd5328;
   localparam int          CHROMA_BIAS = 128 << 16;

   localparam logic [1:0] KIND_HOLD  = 2'd0;
   localparam logic [1:0] KIND_STORE = 2'd1;
   localparam logic [1:0] KIND_QUAD  = 2'd2;
   localparam logic [1:0] KIND_PAIR  = 2'd3;

   typedef struct packed {
      logic [LUMA_OFS_W-1:0] luma_ofs;
      logic [CIDX_W-1:0]     chroma_idx;
      logic                  bias_two;
      logic [LINE_AW-1:0]    line_idx;
      logic [1:0]            kind;
      logic                  yv16;
   } ctx_type;

   function automatic logic [PROD_W-1:0] wmul(input logic [7:0] c, input logic [15:0] k);
      return PROD_W'(c) * PROD_W'(k);
   endfunction

   function automatic logic [7:0] sat8(input logic signed [ACC_W-1:0] acc);
      logic [7:0] q;
      if (acc[ACC_W-1]) begin
         q = 8'd0;
      end else if (acc[ACC_W-2:24] != '0) begin
         q = 8'hFF;
      end else begin
         q = acc[23:16];
      end
      return q;
   endfunction

   // raster position state
   logic [COL_W-1:0]      col_ff, col_in;
   logic [ROW_W-1:0]      row_ff, row_in;
   logic [LUMA_OFS_W-1:0] luma_ofs_ff, luma_ofs_in;
   logic [CIDX_W-1:0]     cidx_ff, cidx_in;
   logic                  bias_odd_ff, bias_odd_in;

   logic    advance, s1_en, accept;
   ctx_type ctx_now;

   logic      s1_valid_ff;
   pixel_type s1_pix_ff;
   ctx_type   s1_ctx_ff;

   logic              s2_valid_ff;
   ctx_type           s2_ctx_ff;
   logic [7:0]        s2_red_ff, s2_blue_ff;
   logic [PROD_W-1:0] s2_y_r_ff, s2_y_g_ff, s2_y_b_ff;
   logic [PROD_W-1:0] s2_u_r_ff, s2_u_g_ff, s2_v_g_ff, s2_v_b_ff;

   logic signed [ACC_W-1:0] y_acc, u_acc, v_acc;

   logic                s3_valid_ff;
   ctx_type             s3_ctx_ff;
   logic [7:0]          s3_y_ff, s3_u_ff, s3_v_ff;
   logic [2*PAIR_W-1:0] line_rd_ff;

   logic [7:0] held_u_ff, held_v_ff;
   logic [2*PAIR_W-1:0] line_mem [LINE_DEPTH];

   logic [PAIR_W-1:0] pu, pv;
   logic [PAIR_W+1:0] quad_u_sum, quad_v_sum, bias_val;
   logic [PAIR_W:0]   pair_u_sum, pair_v_sum;
   logic [OFS_W-1:0]  quad_u_ofs, quad_v_ofs, first_ofs, second_ofs;
   logic              line_wr, is_quad;

   assign advance  = !s3_valid_ff || !grp_full;
   assign s1_en    = advance || !s1_valid_ff;
   assign req_full = !s1_en;
   assign accept   = req_push && s1_en;

   // classify the pixel by its place in the frame
   always_comb begin
      ctx_now.luma_ofs   = luma_ofs_ff;
      ctx_now.chroma_idx = cidx_ff;
      ctx_now.bias_two   = bias_odd_ff;
      ctx_now.line_idx   = col_ff[COL_W-1:1];
      ctx_now.yv16       = (cfg.out_format == FMT_YV16);
      if (!col_ff[0]) begin
         ctx_now.kind = KIND_HOLD;
      end else if (cfg.out_format == FMT_NV12) begin
         ctx_now.kind = row_ff[0] ? KIND_QUAD : KIND_STORE;
      end else begin
         ctx_now.kind = KIND_PAIR;
      end
   end

   always_comb begin
      col_in      = col_ff;
      row_in      = row_ff;
      luma_ofs_in = luma_ofs_ff;
      cidx_in     = cidx_ff;
      bias_odd_in = bias_odd_ff;
      if (restart) begin
         col_in      = '0;
         row_in      = '0;
         luma_ofs_in = '0;
         cidx_in     = '0;
         bias_odd_in = 1'b0;
      end else if (accept) begin
         luma_ofs_in = luma_ofs_ff + 1'b1;
         if (ctx_now.kind == KIND_QUAD || ctx_now.kind == KIND_PAIR) begin
            cidx_in = cidx_ff + 1'b1;
         end
         if (ctx_now.kind == KIND_QUAD) begin
            bias_odd_in = !bias_odd_ff;
         end
         if (DIM_W'(col_ff) + DIM_W'(1) >= cfg.width) begin
            col_in = '0;
            if (DIM_W'(row_ff) + DIM_W'(1) >= cfg.height) begin
               row_in      = '0;
               luma_ofs_in = '0;
               cidx_in     = '0;
               bias_odd_in = 1'b0;
            end else begin
               row_in = row_ff + 1'b1;
            end
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         luma_ofs_ff <= '0;
         cidx_ff     <= '0;
         bias_odd_ff <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         luma_ofs_ff <= luma_ofs_in;
         cidx_ff     <= cidx_in;
         bias_odd_ff <= bias_odd_in;
         if (s1_en) begin
            s1_valid_ff <= accept;
         end
         if (advance) begin
            s2_valid_ff <= s1_valid_ff;
            s3_valid_ff <= s2_valid_ff;
         end
      end
   end

   // weight products
   always_ff @(posedge clock) begin
      if (s1_en) begin
         s1_pix_ff <= req_pixel;
         s1_ctx_ff <= ctx_now;
      end
      if (advance) begin
         s2_ctx_ff  <= s1_ctx_ff;
         s2_red_ff  <= s1_pix_ff.red;
         s2_blue_ff <= s1_pix_ff.blue;
         s2_y_r_ff  <= wmul(s1_pix_ff.red, COEF_Y_R);
         s2_y_g_ff  <= wmul(s1_pix_ff.green, COEF_Y_G);
         s2_y_b_ff  <= wmul(s1_pix_ff.blue, COEF_Y_B);
         s2_u_r_ff  <= wmul(s1_pix_ff.red, COEF_U_R);
         s2_u_g_ff  <= wmul(s1_pix_ff.green, COEF_U_G);
         s2_v_g_ff  <= wmul(s1_pix_ff.green, COEF_V_G);
         s2_v_b_ff  <= wmul(s1_pix_ff.blue, COEF_V_B);
      end
   end

   // sums, floor and clamp
   always_comb begin
      y_acc = $signed({2'b00, s2_y_r_ff}) + $signed({2'b00, s2_y_g_ff})
            + $signed({2'b00, s2_y_b_ff});
      u_acc = $signed({3'b000, s2_blue_ff, 15'd0}) + $signed(ACC_W'(CHROMA_BIAS))
            - $signed({2'b00, s2_u_r_ff}) - $signed({2'b00, s2_u_g_ff});
      v_acc = $signed({3'b000, s2_red_ff, 15'd0}) + $signed(ACC_W'(CHROMA_BIAS))
            - $signed({2'b00, s2_v_g_ff}) - $signed({2'b00, s2_v_b_ff});
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s3_ctx_ff <= s2_ctx_ff;
         s3_y_ff   <= sat8(y_acc);
         s3_u_ff   <= sat8(u_acc);
         s3_v_ff   <= sat8(v_acc);
      end
   end

   // line store of pair sums from the last even row
   assign grp_push = s3_valid_ff && !grp_full;
   assign line_wr  = grp_push && (s3_ctx_ff.kind == KIND_STORE);

   always_ff @(posedge clock) begin
      if (advance) begin
         line_rd_ff <= line_mem[s2_ctx_ff.line_idx];
      end
      if (line_wr) begin
         line_mem[s3_ctx_ff.line_idx] <= {pv, pu};
      end
   end

   // hold chroma of the even column until its partner arrives
   always_ff @(posedge clock) begin
      if (grp_push && s3_ctx_ff.kind == KIND_HOLD) begin
         held_u_ff <= s3_u_ff;
         held_v_ff <= s3_v_ff;
      end
   end

   always_comb begin
      is_quad    = (s3_ctx_ff.kind == KIND_QUAD);
      pu         = {1'b0, held_u_ff} + {1'b0, s3_u_ff};
      pv         = {1'b0, held_v_ff} + {1'b0, s3_v_ff};
      bias_val   = s3_ctx_ff.bias_two ? (PAIR_W+2)'(2) : (PAIR_W+2)'(1);
      quad_u_sum = {2'b00, line_rd_ff[PAIR_W-1:0]} + {2'b00, pu} + bias_val;
      quad_v_sum = {2'b00, line_rd_ff[2*PAIR_W-1:PAIR_W]} + {2'b00, pv} + bias_val;
      pair_u_sum = {1'b0, pu} + (PAIR_W+1)'(1);
      pair_v_sum = {1'b0, pv} + (PAIR_W+1)'(1);
      quad_u_ofs = cfg.luma_size + OFS_W'({s3_ctx_ff.chroma_idx, 1'b0});
      quad_v_ofs = cfg.luma_size + OFS_W'({s3_ctx_ff.chroma_idx, 1'b1});
      first_ofs  = cfg.luma_size + OFS_W'(s3_ctx_ff.chroma_idx);
      second_ofs = cfg.second_base + OFS_W'(s3_ctx_ff.chroma_idx);

      grp.luma_offset = s3_ctx_ff.luma_ofs;
      grp.luma_value  = s3_y_ff;
      grp.has_chroma  = is_quad || (s3_ctx_ff.kind == KIND_PAIR);
      if (is_quad) begin
         grp.u_value  = quad_u_sum[PAIR_W:2];
         grp.v_value  = quad_v_sum[PAIR_W:2];
         grp.u_offset = quad_u_ofs;
         grp.v_offset = quad_v_ofs;
      end else begin
         // a pair sum plus one never exceeds 511, so the top bit stays clear
         grp.u_value  = pair_u_sum[PAIR_W-1:1];
         grp.v_value  = pair_v_sum[PAIR_W-1:1];
         grp.u_offset = s3_ctx_ff.yv16 ? second_ofs : first_ofs;
         grp.v_offset = s3_ctx_ff.yv16 ? first_ofs : second_ofs;
      end
   end

   // a line store write never races a read of the same entry
   a_line_no_race: assert property (@(posedge clock) disable iff (reset)
      line_wr && s2_valid_ff && s2_ctx_ff.kind == KIND_QUAD
      |-> s2_ctx_ff.line_idx != s3_ctx_ff.line_idx)
      else $error("line store read and write of one entry in one cycle");

   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      DIM_W'(col_ff) < cfg.width)
      else $error("column position beyond frame width");

endmodule

FILE: rtl/ryuv_queue.sv
// Short queue of per-pixel result groups between the front and back ends.
module ryuv_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  ryuv_pkg::group_type wr_data,
   output logic                full,
   input  logic                pop,
   output ryuv_pkg::group_type rd_data,
   output logic                empty
);
   import ryuv_pkg::*;

   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   group_type         q_mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;
   logic              push_ok, pop_ok;

   assign full    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign empty   = (count_ff == '0);
   assign push_ok = push && !full;
   assign pop_ok  = pop && !empty;
   assign rd_data = q_mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push_ok) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_ok) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_ok && !pop_ok) begin
         count_in = count_ff + 1'b1;
      end else if (pop_ok && !push_ok) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         q_mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_count_tracks_ptrs: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == QCNT_W'(QUEUE_DEPTH)) |-> wr_ptr_ff == rd_ptr_ff)
      else $error("queue count disagrees with pointers");

endmodule

FILE: rtl/ryuv_back.sv
// Back end: splits result groups into single beats on the result register.
module ryuv_back (
   input  logic                 clock,
   input  logic                 reset,
   input  ryuv_pkg::group_type  q_head,
   input  logic                 q_empty,
   output logic                 q_pop,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output ryuv_pkg::result_type rsp_result
);
   import ryuv_pkg::*;

   logic [1:0] sel_ff, sel_in;
   logic       out_valid_ff;
   result_type out_ff, next_res;
   logic       load, take, last;

   assign load = !out_valid_ff || rsp_pop;
   assign take = load && !q_empty;
   assign last = (sel_ff == PLANE_V) || (sel_ff == PLANE_LUMA && !q_head.has_chroma);
   assign q_pop = take && last;

   always_comb begin
      next_res.last_of_item = last;
      next_res.plane        = sel_ff;
      case (sel_ff)
         PLANE_LUMA: begin
            next_res.byte_offset  = OFS_W'(q_head.luma_offset);
            next_res.sample_value = q_head.luma_value;
         end
         PLANE_U: begin
            next_res.byte_offset  = q_head.u_offset;
            next_res.sample_value = q_head.u_value;
         end
         default: begin
            next_res.byte_offset  = q_head.v_offset;
            next_res.sample_value = q_head.v_value;
         end
      endcase
   end

   always_comb begin
      sel_in = sel_ff;
      if (take) begin
         unique case (sel_ff)
            PLANE_LUMA: sel_in = q_head.has_chroma ? PLANE_U : PLANE_LUMA;
            PLANE_U:    sel_in = PLANE_V;
            default:    sel_in = PLANE_LUMA;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sel_ff       <= PLANE_LUMA;
         out_valid_ff <= 1'b0;
      end else begin
         sel_ff <= sel_in;
         if (load) begin
            out_valid_ff <= !q_empty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         out_ff <= next_res;
      end
   end

   assign rsp_empty  = !out_valid_ff;
   assign rsp_result = out_ff;

   // mid-group the head must still be waiting in the queue
   a_group_held: assert property (@(posedge clock) disable iff (reset)
      sel_ff != PLANE_LUMA |-> !q_empty)
      else $error("chroma beat pending with no group at queue head");

   a_u_not_last: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.plane == PLANE_U |-> !out_ff.last_of_item)
      else $error("U beat marked as last of its pixel");

endmodule

FILE: rtl/rgb_to_yuv_chroma_subsampler.sv
// Top level of the RGB to YUV converter with chroma subsampling.
// Path: a pixel passes the front pipeline and the queue into the result register,
// where it shows as its luma beat; its U and V beats, if any, follow on the next beats.
// Throughput: the front takes one pixel per cycle unless the queue is full; the result
// register moves one beat per cycle while results are popped, so a pixel costs one beat
// (luma only) or three (luma and chroma) on the single result port.
// Reset (synchronous): clears pipeline, queue and raster state; registers return to
// 640 x 480 NV12. The line store is not cleared and needs no clearing pass.
module rgb_to_yuv_chroma_subsampler (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_push,
   output logic                                    req_full,
   input  ryuv_pkg::pixel_type                     req_pixel,
   output logic                                    rsp_empty,
   input  logic                                    rsp_pop,
   output ryuv_pkg::result_type                    rsp_result,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [ryuv_pkg::CSR_INDEX_W-1:0]        csr_index,
   input  logic [ryuv_pkg::DIM_W-1:0]              csr_data
);
   import ryuv_pkg::*;

   localparam logic [DIM_W-1:0] RESET_WIDTH  = DIM_W'(640);
   localparam logic [DIM_W-1:0] RESET_HEIGHT = DIM_W'(480);

   // Clamp a frame dimension to 2..max.
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                   input logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] r;
      if (v < DIM_W'(2)) begin
         r = DIM_W'(2);
      end else if (v > maxv) begin
         r = maxv;
      end else begin
         r = v;
      end
      return r;
   endfunction

   logic [DIM_W-1:0] width_ff, width_in, height_ff, height_in;
   logic [1:0]       format_ff, format_in;
   logic [DIM_W-1:0] w_cl, h_cl;
   logic [OFS_W-1:0] luma_size_ff, chroma_size_ff, second_base_ff;
   logic             csr_write, restart;

   frame_cfg_type cfg;
   group_type     grp, q_head;
   logic          grp_push, grp_full, q_pop, q_empty;

   // Registers are always ready; any write to a known index restarts the frame.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      format_in = format_ff;
      restart   = 1'b0;
      if (csr_write) begin
         unique case (csr_index)
            REG_FRAME_WIDTH: begin
               width_in = csr_data;
               restart  = 1'b1;
            end
            REG_FRAME_HEIGHT: begin
               height_in = csr_data;
               restart   = 1'b1;
            end
            REG_OUT_FORMAT: begin
               format_in = csr_data[1:0];
               restart   = 1'b1;
            end
            default: begin
               restart = 1'b0;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= RESET_WIDTH;
         height_ff <= RESET_HEIGHT;
         format_ff <= FMT_NV12;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
         format_ff <= format_in;
      end
   end

   // Frame geometry: after a register write, luma_size_ff and chroma_size_ff are registered
   // first and second_base_ff after them, ready when the first pixel reaches the offset adders.
   assign w_cl = clamp_dim(width_ff, DIM_W'(MAX_WIDTH));
   assign h_cl = clamp_dim(height_ff, DIM_W'(MAX_HEIGHT));

   // widen before multiplying: 4096 x 4096 needs all 25 bits
   always_ff @(posedge clock) begin
      luma_size_ff   <= OFS_W'(w_cl) * OFS_W'(h_cl);
      chroma_size_ff <= OFS_W'(w_cl >> 1) * OFS_W'(h_cl);
      second_base_ff <= luma_size_ff + chroma_size_ff;
   end

   always_comb begin
      cfg.width       = w_cl;
      cfg.height      = h_cl;
      cfg.out_format  = format_ff;
      cfg.luma_size   = luma_size_ff;
      cfg.second_base = second_base_ff;
   end

   // Front: take pixels, track raster position, convert and average chroma.
   ryuv_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_pixel (req_pixel),
      .cfg       (cfg),
      .restart   (restart),
      .grp_push  (grp_push),
      .grp       (grp),
      .grp_full  (grp_full)
   );

   // Decouple the pixel pipeline from result delivery.
   ryuv_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (grp_push),
      .wr_data (grp),
      .full    (grp_full),
      .pop     (q_pop),
      .rd_data (q_head),
      .empty   (q_empty)
   );

   // Back: hand out one beat per result in luma, U, V order.
   ryuv_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_head     (q_head),
      .q_empty    (q_empty),
      .q_pop      (q_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_result (rsp_result)
   );

endmodule
